>>> hw/rtl/egi_pkg.sv
package egi_pkg;

  // Pipeline depth: one front stage, five surface stages, three divide stages
  localparam int NUM_STAGES = 9;
  typedef logic [NUM_STAGES-1:0] stage_en_t;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FALLBACK = 2'd1;
  localparam logic [1:0] ST_NODATA   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_QUAD  = 2'd0;
  localparam logic [1:0] CFG_SLOPE = 2'd1;
  localparam logic [1:0] CFG_GRID  = 2'd2;

  // Grid classes
  localparam logic [1:0] GRID_30 = 2'd0;
  localparam logic [1:0] GRID_90 = 2'd1;

  localparam logic [2:0] ATTR_NODATA = 3'd7;

  typedef struct packed {
    logic       quad;
    logic       slope;
    logic [1:0] grid;
  } cfg_t;

  typedef struct packed {
    logic                miss;
    logic signed [14:0]  alt;
    logic [2:0]          attr;
  } sample_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         attr;
    logic signed [14:0] calt;
  } info_t;

  // Stage 1 result: decoded altitudes in row order, fractions, status tag
  typedef struct packed {
    logic [8:0][14:0]   g;
    logic signed [16:0] wx;
    logic signed [16:0] wy;
    info_t              info;
  } front_t;

  // Stage 6 result: final height and signed slope numerators
  typedef struct packed {
    logic signed [22:0] height;
    logic signed [48:0] mx;
    logic signed [48:0] my;
    logic [1:0]         status;
    logic [2:0]         attr;
  } surf_t;

  // Split a raw sample into altitude and attribute class
  function automatic sample_t decode_sample(input logic signed [15:0] r);
    logic [16:0]        t;
    logic [2:0]         q;
    logic signed [17:0] a;
    sample_t            s;
    t = 17'(18'(r) + 18'sd41000);
    q = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (t >= 17'(k * 10000)) q = 3'(k);
    end
    a = $signed({1'b0, t}) - $signed(18'(q) * 18'd10000) - 18'sd1000;
    s.miss = (r > 16'sd32000) || (r < -16'sd32000);
    s.alt  = 15'(a);
    s.attr = q;
    return s;
  endfunction

  function automatic logic [9:0] grid_spacing(input logic [1:0] gc);
    unique case (gc)
      GRID_30: return 10'd30;
      GRID_90: return 10'd90;
      default: return 10'd900;
    endcase
  endfunction

  // floor(2^32 / spacing)
  function automatic logic [27:0] grid_recip(input logic [1:0] gc);
    unique case (gc)
      GRID_30: return 28'd143165576;
      GRID_90: return 28'd47721858;
      default: return 28'd4772185;
    endcase
  endfunction

endpackage

>>> hw/rtl/elevation_grid_interpolator.sv
// Channel  | Ports                                             | Direction
// ---------+---------------------------------------------------+----------
// config   | cfg_we, cfg_index, cfg_wdata                      | in
// request  | in_valid/in_stall, in_centre_raw, in_s0..in_s8,   | in
//          | in_frac_x, in_frac_y                              |
// result   | out_valid/out_stall, out_height, out_slope_x,     | out
//          | out_slope_y, out_attribute, out_status            |
//
// Nine register stages: a taken request passes through every stage to the outputs.
// One request per cycle while out_stall is low; every stage holds one request.
// Synchronous active-low reset clears the stage valid bits and the config registers.
// Stalls back up stage by stage: an empty stage still loads while later ones hold,
// so in_stall rises only when all nine stages are full and out_stall is high.
module elevation_grid_interpolator #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [1:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_centre_raw,
  input  logic signed [15:0] in_s0,
  input  logic signed [15:0] in_s1,
  input  logic signed [15:0] in_s2,
  input  logic signed [15:0] in_s3,
  input  logic signed [15:0] in_s4,
  input  logic signed [15:0] in_s5,
  input  logic signed [15:0] in_s6,
  input  logic signed [15:0] in_s7,
  input  logic signed [15:0] in_s8,
  input  logic signed [15:0] in_frac_x,
  input  logic signed [15:0] in_frac_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [22:0] out_height,
  output logic signed [25:0] out_slope_x,
  output logic signed [25:0] out_slope_y,
  output logic [2:0]         out_attribute,
  output logic [1:0]         out_status
);
  import egi_pkg::*;

  cfg_t                  cfg_r;
  logic [NUM_STAGES-1:0] vld_r;
  stage_en_t             adv;
  front_t                front;
  surf_t                 surf;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUAD:  cfg_r.quad  <= cfg_wdata[0];
        CFG_SLOPE: cfg_r.slope <= cfg_wdata[0];
        CFG_GRID:  cfg_r.grid  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    adv[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  egi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk           (clk),
    .adv           (adv),
    .cfg           (cfg_r),
    .in_centre_raw (in_centre_raw),
    .in_s0         (in_s0),
    .in_s1         (in_s1),
    .in_s2         (in_s2),
    .in_s3         (in_s3),
    .in_s4         (in_s4),
    .in_s5         (in_s5),
    .in_s6         (in_s6),
    .in_s7         (in_s7),
    .in_s8         (in_s8),
    .in_frac_x     (in_frac_x),
    .in_frac_y     (in_frac_y),
    .front         (front)
  );

  egi_surface u_surface (
    .clk   (clk),
    .adv   (adv),
    .cfg   (cfg_r),
    .front (front),
    .surf  (surf)
  );

  egi_slope_div u_slope_div (
    .clk           (clk),
    .adv           (adv),
    .cfg           (cfg_r),
    .surf          (surf),
    .out_height    (out_height),
    .out_slope_x   (out_slope_x),
    .out_slope_y   (out_slope_y),
    .out_attribute (out_attribute),
    .out_status    (out_status)
  );

  // Input backs up only when the whole pipe is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r))
    else $error("input stalled with an empty stage");

  // No-data results carry the fixed attribute and zero height
  a_nodata: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NODATA |-> out_attribute == ATTR_NODATA && out_height == '0)
    else $error("no-data result with nonzero fields");

  // Slopes only on interpolated results
  a_slope_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_slope_x == '0 && out_slope_y == '0)
    else $error("slope on a non-interpolated result");

  // Slopes off means zero slopes
  a_slope_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !cfg_r.slope |-> out_slope_x == '0 && out_slope_y == '0)
    else $error("slope output while disabled");

  // Status stays within its defined codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_FALLBACK || out_status == ST_NODATA)
    else $error("undefined status code");

endmodule

>>> hw/rtl/egi_front.sv
module egi_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  egi_pkg::stage_en_t adv,
  input  egi_pkg::cfg_t      cfg,
  input  logic signed [15:0] in_centre_raw,
  input  logic signed [15:0] in_s0,
  input  logic signed [15:0] in_s1,
  input  logic signed [15:0] in_s2,
  input  logic signed [15:0] in_s3,
  input  logic signed [15:0] in_s4,
  input  logic signed [15:0] in_s5,
  input  logic signed [15:0] in_s6,
  input  logic signed [15:0] in_s7,
  input  logic signed [15:0] in_s8,
  input  logic signed [15:0] in_frac_x,
  input  logic signed [15:0] in_frac_y,
  output egi_pkg::front_t    front
);
  import egi_pkg::*;

  localparam int SH_R = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_L = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int HALF = (FRAC_BITS < 16) ? (1 << (FRAC_BITS - 1)) : 32768;
  localparam logic signed [17:0] RND    = 18'((SH_R == 0) ? 0 : (1 << (SH_R - 1)));
  localparam logic signed [17:0] HALF_P = 18'(HALF);
  localparam logic signed [17:0] HALF_N = 18'(-HALF);

  // Clamp to half a cell and rescale to 1/65536 cell
  function automatic logic signed [16:0] to_w(input logic signed [15:0] raw);
    logic signed [17:0] v;
    logic signed [17:0] r;
    v = 18'(raw);
    if (FRAC_BITS >= 16) begin
      r = (v + RND) >>> SH_R;
    end else begin
      if (v > HALF_P) v = HALF_P;
      else if (v < HALF_N) v = HALF_N;
      r = v <<< SH_L;
    end
    return 17'(r);
  endfunction

  sample_t c_dec;
  sample_t s_dec [9];
  logic    any_miss;
  logic    near_miss;
  front_t  front_nxt;
  front_t  front_r;

  // Decode centre and the 3x3 block, stored row by row
  always_comb begin
    c_dec    = decode_sample(in_centre_raw);
    s_dec[0] = decode_sample(in_s0);
    s_dec[1] = decode_sample(in_s1);
    s_dec[2] = decode_sample(in_s4);
    s_dec[3] = decode_sample(in_s2);
    s_dec[4] = decode_sample(in_s3);
    s_dec[5] = decode_sample(in_s5);
    s_dec[6] = decode_sample(in_s6);
    s_dec[7] = decode_sample(in_s7);
    s_dec[8] = decode_sample(in_s8);
    near_miss = s_dec[0].miss | s_dec[1].miss | s_dec[3].miss | s_dec[4].miss;
    any_miss  = near_miss | s_dec[2].miss | s_dec[5].miss | s_dec[6].miss |
                s_dec[7].miss | s_dec[8].miss;
    for (int k = 0; k < 9; k++) begin
      front_nxt.g[k] = s_dec[k].alt;
    end
    front_nxt.wx = to_w(in_frac_x);
    front_nxt.wy = to_w(in_frac_y);
    front_nxt.info.calt = c_dec.alt;
    if (c_dec.miss) begin
      front_nxt.info.status = ST_NODATA;
      front_nxt.info.attr   = ATTR_NODATA;
    end else begin
      front_nxt.info.attr   = c_dec.attr;
      front_nxt.info.status = (cfg.quad ? any_miss : near_miss) ? ST_FALLBACK : ST_OK;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (adv[0]) front_r <= front_nxt;
  end

  assign front = front_r;

endmodule

>>> hw/rtl/egi_surface.sv
module egi_surface (
  input  logic               clk,
  input  egi_pkg::stage_en_t adv,
  input  egi_pkg::cfg_t      cfg,
  input  egi_pkg::front_t    front,
  output egi_pkg::surf_t     surf
);
  import egi_pkg::*;

  localparam logic signed [33:0] WB_BASE = 34'sd6442450944;
  localparam logic signed [50:0] RND21   = 51'sd1048576;
  localparam logic signed [54:0] RND26   = 55'sd33554432;
  localparam logic signed [63:0] RND37   = 64'sd68719476736;

  // ---------------- stage 2: weights and first products ----------------
  logic signed [14:0] g1 [9];
  logic signed [18:0] nx, ux, ny, uy;
  logic signed [17:0] pxm, pxp, pym, pyp;
  logic signed [33:0] wsqx, wsqy;

  always_comb begin
    for (int k = 0; k < 9; k++) g1[k] = signed'(front.g[k]);
    nx   = 19'sd65536 - (19'(front.wx) <<< 1);
    ux   = 19'sd65536 + (19'(front.wx) <<< 1);
    ny   = 19'sd65536 - (19'(front.wy) <<< 1);
    uy   = 19'sd65536 + (19'(front.wy) <<< 1);
    pxm  = 18'(front.wx) - 18'sd32768;
    pxp  = 18'(front.wx) + 18'sd32768;
    pym  = 18'(front.wy) - 18'sd32768;
    pyp  = 18'(front.wy) + 18'sd32768;
    wsqx = 34'(front.wx) * 34'(front.wx);
    wsqy = 34'(front.wy) * 34'(front.wy);
  end

  logic signed [33:0] bp_s2_r [4];
  logic signed [34:0] bs_s2_r [4];
  logic signed [33:0] wxw_s2_r [3];
  logic signed [33:0] wyw_s2_r [3];
  logic [8:0][14:0]   g_s2_r;
  logic signed [18:0] ny_s2_r, uy_s2_r;
  logic signed [16:0] wx_s2_r, wy_s2_r;
  info_t              info_s2_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      bp_s2_r[0]  <= 34'(g1[0]) * 34'(nx);
      bp_s2_r[1]  <= 34'(g1[1]) * 34'(ux);
      bp_s2_r[2]  <= 34'(g1[3]) * 34'(nx);
      bp_s2_r[3]  <= 34'(g1[4]) * 34'(ux);
      bs_s2_r[0]  <= 35'(16'(g1[1]) - 16'(g1[0])) * 35'(ny);
      bs_s2_r[1]  <= 35'(16'(g1[4]) - 16'(g1[3])) * 35'(uy);
      bs_s2_r[2]  <= 35'(16'(g1[3]) - 16'(g1[0])) * 35'(nx);
      bs_s2_r[3]  <= 35'(16'(g1[4]) - 16'(g1[1])) * 35'(ux);
      wxw_s2_r[0] <= 34'(pxm) * 34'(pxm);
      wxw_s2_r[1] <= WB_BASE - (wsqx <<< 1);
      wxw_s2_r[2] <= 34'(pxp) * 34'(pxp);
      wyw_s2_r[0] <= 34'(pym) * 34'(pym);
      wyw_s2_r[1] <= WB_BASE - (wsqy <<< 1);
      wyw_s2_r[2] <= 34'(pyp) * 34'(pyp);
      g_s2_r      <= front.g;
      ny_s2_r     <= ny;
      uy_s2_r     <= uy;
      wx_s2_r     <= front.wx;
      wy_s2_r     <= front.wy;
      info_s2_r   <= front.info;
    end
  end

  // ---------------- stage 3: spline row/column products ----------------
  logic signed [14:0] g2 [9];
  always_comb begin
    for (int k = 0; k < 9; k++) g2[k] = signed'(g_s2_r[k]);
  end

  logic signed [48:0] pd_s3_r [3][3];
  logic signed [48:0] pe_s3_r [3][3];
  logic signed [34:0] br_s3_r [2];
  logic signed [35:0] bn_s3_r [2];
  logic signed [33:0] wyw_s3_r [3];
  logic signed [18:0] ny_s3_r, uy_s3_r;
  logic signed [16:0] wx_s3_r, wy_s3_r;
  info_t              info_s3_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pd_s3_r[i][j] <= 49'(wxw_s2_r[j]) * 49'(g2[i*3+j]);
          pe_s3_r[i][j] <= 49'(wyw_s2_r[j]) * 49'(g2[j*3+i]);
        end
        wyw_s3_r[i] <= wyw_s2_r[i];
      end
      br_s3_r[0] <= 35'(bp_s2_r[0]) + 35'(bp_s2_r[1]);
      br_s3_r[1] <= 35'(bp_s2_r[2]) + 35'(bp_s2_r[3]);
      bn_s3_r[0] <= 36'(bs_s2_r[0]) + 36'(bs_s2_r[1]);
      bn_s3_r[1] <= 36'(bs_s2_r[2]) + 36'(bs_s2_r[3]);
      ny_s3_r    <= ny_s2_r;
      uy_s3_r    <= uy_s2_r;
      wx_s3_r    <= wx_s2_r;
      wy_s3_r    <= wy_s2_r;
      info_s3_r  <= info_s2_r;
    end
  end

  // ---------------- stage 4: first pass sums, bilinear second products ----
  logic signed [50:0] sd [3];
  logic signed [50:0] se [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sd[i] = 51'(pd_s3_r[i][0]) + 51'(pd_s3_r[i][1]) + 51'(pd_s3_r[i][2]);
      se[i] = 51'(pe_s3_r[i][0]) + 51'(pe_s3_r[i][1]) + 51'(pe_s3_r[i][2]);
    end
  end

  logic signed [27:0] d_s4_r [3];
  logic signed [27:0] e_s4_r [3];
  logic signed [53:0] bh_s4_r [2];
  logic signed [35:0] bn_s4_r [2];
  logic signed [33:0] wyw_s4_r [3];
  logic signed [16:0] wx_s4_r, wy_s4_r;
  info_t              info_s4_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < 3; i++) begin
        d_s4_r[i]   <= 28'((sd[i] + RND21) >>> 21);
        e_s4_r[i]   <= 28'((se[i] + RND21) >>> 21);
        wyw_s4_r[i] <= wyw_s3_r[i];
      end
      bh_s4_r[0] <= 54'(br_s3_r[0]) * 54'(ny_s3_r);
      bh_s4_r[1] <= 54'(br_s3_r[1]) * 54'(uy_s3_r);
      bn_s4_r    <= bn_s3_r;
      wx_s4_r    <= wx_s3_r;
      wy_s4_r    <= wy_s3_r;
      info_s4_r  <= info_s3_r;
    end
  end

  // ---------------- stage 5: second pass products, bilinear height -------
  logic signed [29:0] ax, ay;
  logic signed [54:0] sbh;
  always_comb begin
    ax  = 30'(e_s4_r[0]) + 30'(e_s4_r[2]) - (30'(e_s4_r[1]) <<< 1);
    ay  = 30'(d_s4_r[0]) + 30'(d_s4_r[2]) - (30'(d_s4_r[1]) <<< 1);
    sbh = 55'(bh_s4_r[0]) + 55'(bh_s4_r[1]);
  end

  logic signed [61:0] ph_s5_r [3];
  logic signed [47:0] mx_s5_r, my_s5_r;
  logic signed [28:0] cx_s5_r, cy_s5_r;
  logic signed [28:0] hb_s5_r;
  logic signed [35:0] bn_s5_r [2];
  info_t              info_s5_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int j = 0; j < 3; j++) begin
        ph_s5_r[j] <= 62'(wyw_s4_r[j]) * 62'(d_s4_r[j]);
      end
      mx_s5_r   <= 48'(ax) * 48'(18'(wx_s4_r) <<< 1);
      my_s5_r   <= 48'(ay) * 48'(18'(wy_s4_r) <<< 1);
      cx_s5_r   <= 29'(e_s4_r[2]) - 29'(e_s4_r[0]);
      cy_s5_r   <= 29'(d_s4_r[2]) - 29'(d_s4_r[0]);
      hb_s5_r   <= 29'((sbh + RND26) >>> 26);
      bn_s5_r   <= bn_s4_r;
      info_s5_r <= info_s4_r;
    end
  end

  // ---------------- stage 6: height select and slope numerators ----------
  logic signed [63:0] sph;
  logic signed [28:0] hsel;
  logic signed [22:0] hsat;
  surf_t              surf_nxt;
  surf_t              surf_r;

  always_comb begin
    sph  = 64'(ph_s5_r[0]) + 64'(ph_s5_r[1]) + 64'(ph_s5_r[2]);
    hsel = cfg.quad ? 29'(27'((sph + RND37) >>> 37)) : hb_s5_r;
    if (hsel > 29'sd4194303) hsat = 23'sd4194303;
    else if (hsel < -29'sd4194304) hsat = -23'sd4194304;
    else hsat = 23'(hsel);
    case (info_s5_r.status)
      ST_OK:       surf_nxt.height = hsat;
      ST_FALLBACK: surf_nxt.height = 23'(info_s5_r.calt) <<< 8;
      default:     surf_nxt.height = '0;
    endcase
    if (cfg.quad) begin
      surf_nxt.mx = 49'(mx_s5_r) + (49'(cx_s5_r) <<< 16);
      surf_nxt.my = 49'(my_s5_r) + (49'(cy_s5_r) <<< 16);
    end else begin
      surf_nxt.mx = 49'(bn_s5_r[0]);
      surf_nxt.my = 49'(bn_s5_r[1]);
    end
    surf_nxt.status = info_s5_r.status;
    surf_nxt.attr   = info_s5_r.attr;
  end

  always_ff @(posedge clk) begin
    if (adv[5]) surf_r <= surf_nxt;
  end

  assign surf = surf_r;

endmodule

>>> hw/rtl/egi_slope_div.sv
module egi_slope_div (
  input  logic               clk,
  input  egi_pkg::stage_en_t adv,
  input  egi_pkg::cfg_t      cfg,
  input  egi_pkg::surf_t     surf,
  output logic signed [22:0] out_height,
  output logic signed [25:0] out_slope_x,
  output logic signed [25:0] out_slope_y,
  output logic [2:0]         out_attribute,
  output logic [1:0]         out_status
);
  import egi_pkg::*;

  logic [9:0]  sp;
  logic [27:0] recip;
  assign sp    = grid_spacing(cfg.grid);
  assign recip = grid_recip(cfg.grid);

  // Round magnitude down to a numerator whose floor division by spacing is the result
  function automatic logic [31:0] num_round(input logic signed [48:0] m, input logic quad,
                                            input logic [9:0] s);
    logic [48:0] mag;
    logic [48:0] r;
    mag = m[48] ? 49'(-m) : 49'(m);
    if (quad) r = (mag + (49'(s) << 12)) >> 13;
    else r = (mag + 49'(s)) >> 1;
    return 32'(r);
  endfunction

  function automatic logic signed [25:0] sat_slope(input logic [27:0] q, input logic neg);
    if (neg) begin
      if (q > 28'd33554432) return -26'sd33554432;
      return 26'(-$signed({1'b0, q}));
    end
    if (q > 28'd33554431) return 26'sd33554431;
    return 26'(q);
  endfunction

  // ---------------- stage 7: magnitude and rounding offset ----------------
  logic [31:0]        n_s7_r [2];
  logic [1:0]         neg_s7_r;
  logic signed [22:0] h_s7_r;
  logic [1:0]         st_s7_r;
  logic [2:0]         at_s7_r;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      n_s7_r[0] <= num_round(surf.mx, cfg.quad, sp);
      n_s7_r[1] <= num_round(surf.my, cfg.quad, sp);
      neg_s7_r  <= {surf.my[48], surf.mx[48]};
      h_s7_r    <= surf.height;
      st_s7_r   <= surf.status;
      at_s7_r   <= surf.attr;
    end
  end

  // ---------------- stage 8: reciprocal multiply ----------------
  logic [27:0]        qe_s8_r [2];
  logic [31:0]        n_s8_r [2];
  logic [1:0]         neg_s8_r;
  logic signed [22:0] h_s8_r;
  logic [1:0]         st_s8_r;
  logic [2:0]         at_s8_r;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      for (int a = 0; a < 2; a++) begin
        qe_s8_r[a] <= 28'((64'(n_s7_r[a]) * 64'(recip)) >> 32);
      end
      n_s8_r   <= n_s7_r;
      neg_s8_r <= neg_s7_r;
      h_s8_r   <= h_s7_r;
      st_s8_r  <= st_s7_r;
      at_s8_r  <= at_s7_r;
    end
  end

  // ---------------- stage 9: correct estimate, sign, saturate ----------------
  logic [37:0]        rem [2];
  logic [27:0]        q [2];
  logic signed [25:0] sl [2];
  logic               slope_on;

  always_comb begin
    slope_on = cfg.slope && (st_s8_r == ST_OK);
    for (int a = 0; a < 2; a++) begin
      rem[a] = 38'(n_s8_r[a]) - 38'(qe_s8_r[a]) * 38'(sp);
      q[a]   = qe_s8_r[a] + 28'(rem[a] >= 38'(sp));
      sl[a]  = slope_on ? sat_slope(q[a], neg_s8_r[a]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      out_height    <= h_s8_r;
      out_slope_x   <= sl[0];
      out_slope_y   <= sl[1];
      out_attribute <= at_s8_r;
      out_status    <= st_s8_r;
    end
  end

endmodule

>>> bench/tb_top.sv
module tb_top;
  import egi_pkg::*;

  localparam int FRACB = 16;
  localparam longint ONE_W = 65536;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PIPE_DEPTH = 9;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_centre_raw = '0;
  logic signed [15:0] in_s0 = '0, in_s1 = '0, in_s2 = '0, in_s3 = '0, in_s4 = '0;
  logic signed [15:0] in_s5 = '0, in_s6 = '0, in_s7 = '0, in_s8 = '0;
  logic signed [15:0] in_frac_x = '0, in_frac_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [22:0] out_height;
  logic signed [25:0] out_slope_x, out_slope_y;
  logic [2:0] out_attribute;
  logic [1:0] out_status;

  typedef struct {
    logic signed [15:0] centre;
    logic signed [15:0] s[9];
    logic signed [15:0] fx;
    logic signed [15:0] fy;
  } point_t;

  typedef struct {
    logic signed [22:0] height;
    logic signed [25:0] sx;
    logic signed [25:0] sy;
    logic [2:0] attr;
    logic [1:0] status;
  } terrain_t;

  terrain_t expected_q[$];
  cfg_t mode;
  int errors = 0;
  int points_sent = 0;
  int results_seen = 0;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit rand_stall = 1'b0;

  elevation_grid_interpolator u_top (.*);

  always #10 clk = ~clk;

  // abort on a hung pipeline
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("elevation_grid_interpolator: mismatch");
      $finish;
    end
  end

  function automatic bit is_missing(int r);
    return r > 32000 || r < -32000;
  endfunction

  function automatic longint alt_of(int r);
    return longint'((r + 41000) % 10000) - 1000;
  endfunction

  // round to nearest, ties toward +inf
  function automatic longint rshift_rnd(longint x, int sh);
    return (x + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  // round to nearest, ties away from zero
  function automatic longint div_rnd(longint n, longint d);
    longint m, q;
    m = n < 0 ? -n : n;
    q = (m + d / 2) / d;
    return n < 0 ? -q : q;
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint bspline(longint a, longint b, longint c, longint w);
    return (2 * w - ONE_W) * (2 * w - ONE_W) * a + (6 * ONE_W * ONE_W - 8 * w * w) * b
           + (2 * w + ONE_W) * (2 * w + ONE_W) * c;
  endfunction

  function automatic longint bspline_d(longint a, longint b, longint c, longint w);
    return 2 * w * (a + c - 2 * b) + ONE_W * (c - a);
  endfunction

  // expected terrain value for one point under the current mode
  function automatic terrain_t predict_terrain(point_t p);
    terrain_t t;
    longint g[3][3];
    longint h, sx, sy, wx, wy, sp, d[3], e[3];
    longint nx, ux, ny, uy, r0, r1;
    int idx[3][3];
    int n;
    bit gap;
    idx = '{'{0, 1, 4}, '{2, 3, 5}, '{6, 7, 8}};
    h = 0; sx = 0; sy = 0; gap = 0;
    t.attr = ATTR_NODATA;
    sp = mode.grid == GRID_30 ? 30 : (mode.grid == GRID_90 ? 90 : 900);
    n = mode.quad ? 3 : 2;
    if (is_missing(p.centre)) begin
      t.status = ST_NODATA;
    end else begin
      t.attr = 3'((int'(p.centre) + 41000) / 10000);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          if (i < n && j < n && is_missing(p.s[idx[i][j]])) gap = 1;
          g[i][j] = alt_of(p.s[idx[i][j]]);
        end
      if (gap) begin
        t.status = ST_FALLBACK;
        h = alt_of(p.centre) * 256;
      end else begin
        t.status = ST_OK;
        wx = clip(p.fx, -(1 << (FRACB - 1)), 1 << (FRACB - 1));
        wy = clip(p.fy, -(1 << (FRACB - 1)), 1 << (FRACB - 1));
        if (!mode.quad) begin
          nx = ONE_W - 2 * wx; ux = ONE_W + 2 * wx;
          ny = ONE_W - 2 * wy; uy = ONE_W + 2 * wy;
          r0 = g[0][0] * nx + g[0][1] * ux;
          r1 = g[1][0] * nx + g[1][1] * ux;
          h = rshift_rnd(r0 * ny + r1 * uy, 26);
          sx = div_rnd((g[0][1] - g[0][0]) * ny + (g[1][1] - g[1][0]) * uy, 2 * sp);
          sy = div_rnd((g[1][0] - g[0][0]) * nx + (g[1][1] - g[0][1]) * ux, 2 * sp);
        end else begin
          for (int i = 0; i < 3; i++) begin
            d[i] = rshift_rnd(bspline(g[i][0], g[i][1], g[i][2], wx), 23);
            e[i] = rshift_rnd(bspline(g[0][i], g[1][i], g[2][i], wy), 23);
          end
          h = rshift_rnd(bspline(d[0], d[1], d[2], wy), 39);
          sx = div_rnd(bspline_d(e[0], e[1], e[2], wx), 8192 * sp);
          sy = div_rnd(bspline_d(d[0], d[1], d[2], wy), 8192 * sp);
        end
        if (!mode.slope) begin
          sx = 0; sy = 0;
        end
      end
    end
    t.height = 23'(clip(h, -4194304, 4194303));
    t.sx = 26'(clip(sx, -33554432, 33554431));
    t.sy = 26'(clip(sy, -33554432, 33554431));
    return t;
  endfunction

  // offer one point; valid stays up after the handoff so a following point can go back to back
  task automatic send_point(point_t p);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_centre_raw <= p.centre;
    {in_s0, in_s1, in_s2, in_s3, in_s4} <= {p.s[0], p.s[1], p.s[2], p.s[3], p.s[4]};
    {in_s5, in_s6, in_s7, in_s8} <= {p.s[5], p.s[6], p.s[7], p.s[8]};
    in_frac_x <= p.fx;
    in_frac_y <= p.fy;
    // hold until taken
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_terrain(p));
    points_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_QUAD: mode.quad = value[0];
      CFG_SLOPE: mode.slope = value[0];
      CFG_GRID: mode.grid = value;
      default: ;
    endcase
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  task automatic set_mode(bit quad, bit slope, logic [1:0] grid);
    drain();
    write_reg(CFG_QUAD, {1'b0, quad});
    write_reg(CFG_SLOPE, {1'b0, slope});
    write_reg(CFG_GRID, grid);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 19))
      0: return 16'sd32767;
      1: return 16'($urandom);
      2: return 16'sd32000;
      3: return -16'sd32000;
      default: return 16'($signed($urandom_range(0, 64000)) - 32000);
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    bit clean;
    clean = $urandom_range(0, 9) < 7;
    p.centre = rand_sample();
    foreach (p.s[k]) p.s[k] = rand_sample();
    if (clean) begin
      if (is_missing(p.centre)) p.centre = 16'($signed($urandom_range(0, 64000)) - 32000);
      foreach (p.s[k])
        if (is_missing(p.s[k])) p.s[k] = 16'($signed($urandom_range(0, 64000)) - 32000);
    end
    p.fx = 16'($urandom);
    p.fy = 16'($urandom);
    return p;
  endfunction

  // corners of the sample range and fractions, both modes
  task automatic test_directed;
    point_t p;
    logic signed [15:0] vals[5];
    vals = '{-16'sd32000, 16'sd32000, 16'sd0, -16'sd32001, 16'sd32767};
    for (int m = 0; m < 2; m++) begin
      set_mode(m[0], 1'b1, GRID_30);
      for (int k = 0; k < 10; k++) begin
        p.centre = (k == 0) ? 16'sd32767 : vals[k % 3];
        foreach (p.s[j]) p.s[j] = vals[(k + j) % 3];
        if (k == 1) p.s[4] = 16'sd32767;
        if (k == 2) p.s[1] = -16'sd32001;
        if (k == 3) p.s[8] = -16'sd32768;
        p.fx = (k % 2) ? 16'sh7fff : 16'sh8000;
        p.fy = (k % 4 < 2) ? 16'sh4000 : -16'sh4000;
        if (k == 4) begin
          p.fx = 16'sh0000; p.fy = 16'sh0000;
        end
        send_point(p);
      end
    end
  endtask

  task automatic test_random(int count);
    for (int k = 0; k < count; k++) send_point(rand_point());
  endtask

  // long receiver hold-off while points keep coming
  task automatic test_backpressure;
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(negedge clk);
        hold_off = 1'b0;
      end
      test_random(40);
    join
  endtask

  // drive out_stall from random draws or the hold-off
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || (rand_stall && $urandom_range(0, 10) < 4);
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    terrain_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result, height %0d", out_height);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_height !== e.height) begin
          $error("height exp %0d got %0d", e.height, out_height); errors++;
        end
        if (out_slope_x !== e.sx) begin
          $error("slope_x exp %0d got %0d", e.sx, out_slope_x); errors++;
        end
        if (out_slope_y !== e.sy) begin
          $error("slope_y exp %0d got %0d", e.sy, out_slope_y); errors++;
        end
        if (out_attribute !== e.attr) begin
          $error("attribute exp %0d got %0d", e.attr, out_attribute); errors++;
        end
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); errors++;
        end
      end
    end
  end

  initial begin
    mode = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    rand_stall = 1'b1;
    set_mode(1'b0, 1'b1, GRID_30);
    test_backpressure();
    for (int m = 0; m < 8; m++) begin
      set_mode(m[0], m[1] | m[2], 2'(m % 4));
      test_random(230);
    end
    rand_stall = 1'b0;
    set_mode(1'b1, 1'b1, 2'd3);
    test_random(50);
    set_mode(1'b0, 1'b0, GRID_90);
    test_random(20);
    drain();
    $display("Sent %0d points over bilinear and biquadratic modes, all grid classes,",
             points_sent);
    $display("with and without slopes; %0d results checked.", results_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("elevation_grid_interpolator: match");
    end else begin
      $display("elevation_grid_interpolator: mismatch");
    end
    $finish;
  end
endmodule
